FILE: hdl/bbs_pkg.sv
// Package for the 3x3 box blur stream: field widths, register indexes,
// result and stage types, divide-by-nine constants. No dependencies.
package bbs_pkg;

  localparam int PIX_W    = 8;
  localparam int CFG_W    = 12;
  localparam int POS_W    = 11;
  localparam int COLSUM_W = 10;
  localparam int TOTAL_W  = 12;

  localparam int MAX_HEIGHT = 2048;
  localparam int MIN_DIM    = 3;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // floor(x / 9) == (x * 7282) >> 16 for every x below 32768
  localparam int DIV_MULT  = 7282;
  localparam int DIV_SHIFT = 16;
  localparam int PROD_W    = 25;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 1'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 1'd1;

  typedef struct packed {
    logic [PIX_W-1:0] blurred_pixel;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             frame_last;
  } res_t;

  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } tag_t;

endpackage

FILE: hdl/bbs_pix_if.sv
// Pixel input channel: valid/ready handshake with one 8-bit pixel per item.
// Depends on bbs_pkg.
interface bbs_pix_if;
  import bbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

FILE: hdl/bbs_res_if.sv
// Result output channel: valid/ready handshake carrying bbs_pkg::res_t.
// Depends on bbs_pkg.
interface bbs_res_if;
  import bbs_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/bbs_line_buf.sv
// Two line stores for the previous two rows, one read port with registered
// data and one write port each. Depends on bbs_pkg.
module bbs_line_buf #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
  input  logic [bbs_pkg::PIX_W-1:0]      px,
  input  logic                           wr_b_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]   wr_b_addr,
  input  logic [bbs_pkg::PIX_W-1:0]      wr_b_data,
  output logic [bbs_pkg::PIX_W-1:0]      rd_top,
  output logic [bbs_pkg::PIX_W-1:0]      rd_mid
);
  import bbs_pkg::*;

  logic [PIX_W-1:0] mem_a [MAX_WIDTH];
  logic [PIX_W-1:0] mem_b [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_mid <= mem_a[rd_addr];
      mem_a[rd_addr] <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top <= mem_b[rd_addr];
    end
    if (wr_b_en) begin
      mem_b[wr_b_addr] <= wr_b_data;
    end
  end

endmodule

FILE: hdl/bbs_mean.sv
// Window column sums, window total and divide-by-nine output stage with the
// result register. Depends on bbs_pkg and bbs_res_if.
module bbs_mean (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [bbs_pkg::PIX_W-1:0] top,
  input  logic [bbs_pkg::PIX_W-1:0] mid,
  input  logic [bbs_pkg::PIX_W-1:0] px,
  input  bbs_pkg::tag_t             tag_in,
  output logic                      can_load,
  bbs_res_if.source                 res
);
  import bbs_pkg::*;

  logic [COLSUM_W-1:0] colsum0;
  logic [COLSUM_W-1:0] colsum1;
  logic [COLSUM_W-1:0] colsum2;
  logic                v2;
  tag_t                tag2;
  logic                v3;
  tag_t                tag3;
  logic [TOTAL_W-1:0]  total;
  logic                out_valid;
  res_t                out_data;
  logic                out_en;
  logic                en3;
  logic [COLSUM_W-1:0] colsum_next;
  logic [PROD_W-1:0]   prod;

  assign out_en   = !out_valid || res.ready;
  assign en3      = !v3 || out_en;
  assign can_load = !v2 || en3;

  assign colsum_next = COLSUM_W'(top) + COLSUM_W'(mid) + COLSUM_W'(px);
  assign prod        = PROD_W'(total) * PROD_W'(DIV_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      colsum0 <= '0;
      colsum1 <= '0;
      colsum2 <= '0;
      v2      <= 1'b0;
    end else if (load) begin
      colsum0 <= colsum1;
      colsum1 <= colsum2;
      colsum2 <= colsum_next;
      v2      <= tag_in.emit;
    end else if (en3) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag2 <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      total <= TOTAL_W'(colsum0) + TOTAL_W'(colsum1) + TOTAL_W'(colsum2);
      tag3  <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data.blurred_pixel <= prod[DIV_SHIFT +: PIX_W];
      out_data.out_col       <= tag3.col;
      out_data.out_row       <= tag3.row;
      out_data.frame_last    <= tag3.last;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

endmodule

FILE: hdl/box_blur_3x3_stream.sv
// Top level of the 3x3 box blur stream: configuration registers, raster
// counters, read stage and pipeline. Depends on bbs_pkg, bbs_pix_if,
// bbs_res_if, bbs_line_buf and bbs_mean.
//
//   channel  dir  payload                                      handshake
//   pix      in   pixel_in[7:0]                                valid/ready
//   res      out  blurred_pixel, out_col, out_row, frame_last  valid/ready
//   cfg      in   cfg_index, cfg_wdata[11:0]                   cfg_wr_en only
//
// One pixel is accepted per cycle while res is not stalled; a result leaves
// through the line-store read register, the column-sum stage, the window
// total stage and the result register.
// Reset is synchronous and clears counters, valid flags and the window.
// A stall at res backs up stage by stage; pix.ready drops only once
// every stage holds an item.
module box_blur_3x3_stream #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  bbs_pkg::cfg_idx_t         cfg_index,
  input  logic [bbs_pkg::CFG_W-1:0] cfg_wdata,
  bbs_pix_if.sink                   pix,
  bbs_res_if.source                 res
);
  import bbs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int HW = POS_W + 1;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [EW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [EW-1:0]    w_raw;
  logic [HW-1:0]    h_raw;

  logic [CW-1:0]    col_count;
  logic [POS_W-1:0] row_count;
  logic [CW-1:0]    col_count_next;
  logic [POS_W-1:0] row_count_next;
  logic [EW-1:0]    c_ext;
  logic [EW-1:0]    c_plus;
  logic [HW-1:0]    r_ext;
  logic [HW-1:0]    r_plus;
  logic [CW-1:0]    c_minus;

  logic             accept;
  logic             v1;
  logic             en1;
  logic             can_load;
  logic             load2;
  logic [PIX_W-1:0] px1;
  logic [CW-1:0]    col1;
  tag_t             tag1;
  tag_t             tag_next;
  logic [PIX_W-1:0] rd_top;
  logic [PIX_W-1:0] rd_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_raw = EW'(image_width);
  assign h_raw = HW'(image_height);

  always_comb begin
    if (w_raw < EW'(MIN_DIM)) begin
      w_eff = EW'(MIN_DIM);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < HW'(MIN_DIM)) begin
      h_eff = HW'(MIN_DIM);
    end else if (h_raw > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  assign c_ext   = EW'(col_count);
  assign c_plus  = c_ext + EW'(1);
  assign r_ext   = HW'(row_count);
  assign r_plus  = r_ext + HW'(1);
  assign c_minus = col_count - CW'(1);

  always_comb begin
    if (c_plus >= w_eff) begin
      col_count_next = '0;
      row_count_next = (r_plus >= h_eff) ? '0 : POS_W'(r_plus);
    end else begin
      col_count_next = CW'(c_plus);
      row_count_next = row_count;
    end
    tag_next.emit = (c_ext >= EW'(2)) && (r_ext >= HW'(2)) &&
                    (c_ext < w_eff) && (r_ext < h_eff);
    tag_next.col  = POS_W'(c_minus);
    tag_next.row  = row_count - POS_W'(1);
    tag_next.last = (c_plus == w_eff) && (r_plus == h_eff);
  end

  assign load2     = v1 && can_load;
  assign en1       = !v1 || can_load;
  assign pix.ready = en1;
  assign accept    = pix.valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      v1        <= 1'b0;
    end else begin
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      if (en1) begin
        v1 <= pix.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1  <= pix.pixel_in;
      col1 <= col_count;
      tag1 <= tag_next;
    end
  end

  bbs_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (col_count),
    .px       (pix.pixel_in),
    .wr_b_en  (load2),
    .wr_b_addr(col1),
    .wr_b_data(rd_mid),
    .rd_top   (rd_top),
    .rd_mid   (rd_mid)
  );

  bbs_mean u_mean (
    .clk     (clk),
    .rst     (rst),
    .load    (load2),
    .top     (rd_top),
    .mid     (rd_mid),
    .px      (px1),
    .tag_in  (tag1),
    .can_load(can_load),
    .res     (res)
  );

endmodule
